// ===== hw/rtl/gain_clamp_moving_average_threshold_defines.svh =====
// ----------------------------------------------------------------------------
// gain_clamp_moving_average_threshold assertion macros
// Shared concurrent assertion forms for the level averaging block.
// ----------------------------------------------------------------------------
`ifndef GAIN_CLAMP_MOVING_AVERAGE_THRESHOLD_DEFINES_SVH
`define GAIN_CLAMP_MOVING_AVERAGE_THRESHOLD_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GCMAT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GCMAT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gcmat_pkg.sv =====
// ----------------------------------------------------------------------------
// gcmat_pkg
// Types and constants for the gain, clamp, moving average and threshold block.
// ----------------------------------------------------------------------------
package gcmat_pkg;

  localparam int LEVEL_W    = 11;
  localparam int SAMPLE_W   = 8;
  localparam int GAIN_W     = 12;
  localparam int WINLEN_W   = 7;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;

  localparam int DEFAULT_MAX_WINDOW = 64;

  localparam logic [LEVEL_W-1:0] FULL_SCALE  = 11'd2032;
  localparam logic [7:0]         BLEND_LEVEL = 8'd205;
  localparam logic [7:0]         BLEND_MEAN  = 8'd51;

  localparam logic [GAIN_W-1:0]   GAIN_RESET     = 12'd256;
  localparam logic [WINLEN_W-1:0] WINLEN_RESET   = 7'd50;
  localparam logic [LEVEL_W-1:0]  ACTIVE_RESET   = 11'd80;
  localparam logic [LEVEL_W-1:0]  LOUD_RESET     = 11'd960;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN        = 3'd0,
    REG_WINDOW      = 3'd1,
    REG_ACTIVE_THR  = 3'd2,
    REG_LOUD_THR    = 3'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SUM,
    ST_DIV,
    ST_BLEND
  } state_t;

endpackage

// ===== hw/rtl/gcmat_hist_mem.sv =====
// ----------------------------------------------------------------------------
// gcmat_hist_mem
// Level history RAM, one write and one registered read port per cycle.
// Per-entry valid bits make never-written entries read as zero.
// ----------------------------------------------------------------------------
module gcmat_hist_mem
  import gcmat_pkg::*;
#(
  parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [LEVEL_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [LEVEL_W-1:0] rdata
);

  logic [LEVEL_W-1:0]    mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] valid;
  logic [LEVEL_W-1:0]    q;
  logic                  q_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      q_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        q_valid <= valid[raddr];
      end
    end
  end

  assign rdata = q_valid ? q : '0;

endmodule

// ===== hw/rtl/gcmat_div.sv =====
// ----------------------------------------------------------------------------
// gcmat_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcmat_div
  import gcmat_pkg::*;
#(
  parameter int NUM_W = 18,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] qd;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, qd[NUM_W-1]};
    diff  = trial - {1'b0, den};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      qd  <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      qd  <= {qd[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = qd;

endmodule

// ===== hw/rtl/gain_clamp_moving_average_threshold.sv =====
// Flow: an accepted sample is scaled and clamped; the W - 1 older entries (W = effective
//   window) are read from the history RAM and summed; the NUM_W-bit sum (NUM_W = 11 +
//   clog2(MAX_WINDOW+1), 18 at the default depth) is divided by W bit-serially; level and
//   mean are blended and registered. Items are taken only in idle, after the last result is
//   loaded; the single history RAM read port (one entry per cycle) and the divider set pace.
// Reset: synchronous, active high; registers return to defaults, history reads as zero.
// ----------------------------------------------------------------------------
// gain_clamp_moving_average_threshold
// Scales and clamps a level sample, keeps a windowed mean over a RAM history,
// blends level and mean, and flags two threshold crossings.
// ----------------------------------------------------------------------------
module gain_clamp_moving_average_threshold
  import gcmat_pkg::*;
#(
  parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // sample channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   sample,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEVEL_W-1:0]    level,
  output logic [LEVEL_W-1:0]    mean_level,
  output logic [LEVEL_W-1:0]    blended_level,
  output logic                  active,
  output logic                  loud
);

`include "gain_clamp_moving_average_threshold_defines.svh"

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW    = $clog2(MAX_WINDOW + 1);   // holds 1..MAX_WINDOW
  localparam int SUM_W = LEVEL_W + WW;             // sum of MAX_WINDOW levels

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]   gain;
  logic [WINLEN_W-1:0] window_length;
  logic [LEVEL_W-1:0]  active_threshold;
  logic [LEVEL_W-1:0]  loud_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain             <= GAIN_RESET;
      window_length    <= WINLEN_RESET;
      active_threshold <= ACTIVE_RESET;
      loud_threshold   <= LOUD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN:       gain             <= cfg_data;
        REG_WINDOW:     window_length    <= cfg_data[WINLEN_W-1:0];
        REG_ACTIVE_THR: active_threshold <= cfg_data[LEVEL_W-1:0];
        REG_LOUD_THR:   loud_threshold   <= cfg_data[LEVEL_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Effective window: zero acts as one, clipped to the history depth.
  logic [WW-1:0] win_eff;
  always_comb begin
    if (window_length == '0) begin
      win_eff = WW'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      win_eff = WW'(MAX_WINDOW);
    end else begin
      win_eff = WW'(window_length);
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  state_t state, state_next;

  logic [SAMPLE_W-1:0] smp;
  logic [LEVEL_W-1:0]  lvl;        // clamped level of the item in flight
  logic [LEVEL_W-1:0]  lvl_next;
  logic [SUM_W-1:0]    sum;
  logic [LEVEL_W-1:0]  mean;
  logic [AW-1:0]       head;       // slot the next level goes into
  logic [AW-1:0]       rd_addr;
  logic [WW-1:0]       rd_left;    // older entries still to read
  logic                rd_pend;    // a read returns this cycle

  // strobes from the controller
  logic accept;
  logic mem_we;
  logic rd_issue;
  logic div_start;
  logic out_load;

  logic [LEVEL_W-1:0]  rdata;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;

  // Scale: Q0 sample times Q4.8 gain, drop four fraction bits, clamp.
  logic [SAMPLE_W+GAIN_W-1:0] prod;
  always_comb begin
    prod = (SAMPLE_W+GAIN_W)'(smp) * (SAMPLE_W+GAIN_W)'(gain);
    if (prod[SAMPLE_W+GAIN_W-1:4] > (SAMPLE_W+GAIN_W-4)'(FULL_SCALE)) begin
      lvl_next = FULL_SCALE;
    end else begin
      lvl_next = prod[LEVEL_W+3:4];
    end
  end

  // Blend about 0.8 level and 0.2 mean.
  logic [LEVEL_W+8:0] blend_acc;
  assign blend_acc = (LEVEL_W+9)'(BLEND_LEVEL) * (LEVEL_W+9)'(lvl)
                   + (LEVEL_W+9)'(BLEND_MEAN) * (LEVEL_W+9)'(mean);

  // Slot just older than the newest one.
  logic [AW-1:0] head_prev;
  logic [AW-1:0] head_succ;
  logic [AW-1:0] rd_addr_prev;
  assign head_prev    = (head == '0) ? AW'(MAX_WINDOW - 1) : head - AW'(1);
  assign head_succ    = (head == AW'(MAX_WINDOW - 1)) ? '0 : head + AW'(1);
  assign rd_addr_prev = (rd_addr == '0) ? AW'(MAX_WINDOW - 1) : rd_addr - AW'(1);

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_SUM;
      ST_SUM:   if (rd_left == '0 && !rd_pend) state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_BLEND;
      ST_BLEND: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    mem_we    = 1'b0;
    rd_issue  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ST_SCALE: ;
      ST_SUM: begin
        // the level write hits head; reads walk older slots, never head
        mem_we    = !rd_pend && (rd_left == win_eff - WW'(1));
        rd_issue  = rd_left != '0;
        div_start = rd_left == '0 && !rd_pend;
      end
      ST_DIV: ;
      ST_BLEND: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // first SUM cycle flag keeps the write to a single cycle
  logic first_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      rd_pend   <= 1'b0;
      rd_left   <= '0;
      first_sum <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_issue;
      if (state == ST_SCALE) begin
        rd_left   <= win_eff - WW'(1);
        first_sum <= 1'b1;
      end else if (rd_issue) begin
        rd_left   <= rd_left - WW'(1);
        first_sum <= 1'b0;
      end else if (state == ST_SUM) begin
        first_sum <= 1'b0;
      end
      if (div_start) begin
        head <= head_succ;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp <= sample;
    end
    if (state == ST_SCALE) begin
      lvl     <= lvl_next;
      sum     <= SUM_W'(lvl_next);
      rd_addr <= head_prev;
    end else begin
      if (rd_issue) begin
        rd_addr <= rd_addr_prev;
      end
      if (rd_pend) begin
        sum <= sum + SUM_W'(rdata);
      end
    end
    if (div_done) begin
      mean <= quotient[LEVEL_W-1:0];
    end
    if (out_load) begin
      level         <= lvl;
      mean_level    <= mean;
      blended_level <= blend_acc[LEVEL_W+7:8];
      active        <= lvl > active_threshold;
      loud          <= lvl > loud_threshold;
    end
  end

  // --------------------------------------------------------------------------
  // History RAM and divider
  // --------------------------------------------------------------------------
  gcmat_hist_mem #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we && first_sum),
    .waddr (head),
    .wdata (lvl),
    .re    (rd_issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  gcmat_div #(
    .NUM_W (SUM_W),
    .DEN_W (WW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (win_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `GCMAT_ASSERT_NXT(a_accept_scale, clk, rst, accept, state == ST_SCALE, "accept did not scale")
  `GCMAT_ASSERT_NXT(a_div_blend, clk, rst, state == ST_DIV && div_done, state == ST_BLEND, "div lost")
  `GCMAT_ASSERT_IMP(a_level_fs, clk, rst, out_valid, level <= FULL_SCALE, "level over full scale")
  `GCMAT_ASSERT_IMP(a_mean_fs, clk, rst, out_valid, mean_level <= FULL_SCALE, "mean over full scale")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: level averaging block testbench
// Drives raw level samples through the gain, clamp, moving average and
// threshold block. It checks every result against an in-bench predictor with
// its own history and register copies, or a typed-in result on a directed row.
// A short directed table covers the extremes and corner cases, then randomized
// phases follow, each with new register settings. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import gcmat_pkg::*;

  // --------------------------------------------------------------------------
  // Run shape
  // --------------------------------------------------------------------------
  localparam int DEPTH          = DEFAULT_MAX_WINDOW;
  localparam int RESET_CYCLES   = 8;
  localparam int MAX_GAP        = 30;    // longest sender gap between bursts
  localparam int MAX_RUN        = 40;    // longest receiver stall run
  localparam int SETTLE_CYCLES  = 4;     // quiet cycles before a register write
  localparam int DRAIN_CYCLES   = 120;   // quiet wait after the last expected result
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no item moving either way
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 157;
  localparam int MAX_REPORTS    = 10;

  // Indexes past the last register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] BAD_IDX_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] BAD_IDX_LAST  = 3'd7;

  // Receiver stall patterns.
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_RUNS} rx_mode_t;

  // One result item, packed in port order.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] mean;
    logic [LEVEL_W-1:0] blend;
    logic               active;
    logic               loud;
  } level_res_t;

  // One row of the directed table: a register write or a sample, with an
  // optional typed-in result.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [SAMPLE_W-1:0]   smp;
    bit                    typed;
    level_res_t            res;
  } step_row_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   sample;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LEVEL_W-1:0]    level;
  logic [LEVEL_W-1:0]    mean_level;
  logic [LEVEL_W-1:0]    blended_level;
  logic                  active;
  logic                  loud;

  gain_clamp_moving_average_threshold dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .level         (level),
    .mean_level    (mean_level),
    .blended_level (blended_level),
    .active        (active),
    .loud          (loud)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the level history (entry 0 newest)
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]   gain_r;
  logic [WINLEN_W-1:0] window_r;
  logic [LEVEL_W-1:0]  act_thr_r;
  logic [LEVEL_W-1:0]  loud_thr_r;
  logic [LEVEL_W-1:0]  hist [DEPTH];

  level_res_t expected_levels [$];
  step_row_t  dir_rows [$];

  int samples_sent = 0;
  int results_seen = 0;
  int reg_writes   = 0;
  int settings     = 0;
  int fail_count   = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;

  // receiver pattern state
  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_left  = 0;
  int       run_left = 0;
  bit       run_stall = 1'b0;

  // Scale, clamp, push into history, then average and blend into the expected result.
  function automatic level_res_t predict_level(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W+GAIN_W-1:0] prod;
    logic [LEVEL_W-1:0]         lvl;
    int unsigned                w;
    int unsigned                sum;
    int unsigned                mean;
    int unsigned                blend;
    level_res_t                 r;
    prod = (SAMPLE_W+GAIN_W)'(s) * (SAMPLE_W+GAIN_W)'(gain_r);
    // Q.8 gain product back to Q.4, truncated, clamped at full scale
    if ((prod >> 4) > (SAMPLE_W+GAIN_W)'(FULL_SCALE)) lvl = FULL_SCALE;
    else lvl = prod[LEVEL_W+3:4];
    for (int i = DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = lvl;
    // window zero acts as one, anything past the depth as the depth
    w = 32'(window_r);
    if (w < 1) w = 1;
    if (w > DEPTH) w = DEPTH;
    sum = 0;
    for (int i = 0; i < w; i++) sum += 32'(hist[i]);
    mean  = sum / w;
    blend = (32'(BLEND_LEVEL) * 32'(lvl) + 32'(BLEND_MEAN) * mean) >> 8;
    r.level  = lvl;
    r.mean   = mean[LEVEL_W-1:0];
    r.blend  = blend[LEVEL_W-1:0];
    r.active = (lvl > act_thr_r);
    r.loud   = (lvl > loud_thr_r);
    return r;
  endfunction

  function automatic step_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] d);
    step_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = d;
    r.smp    = '0;
    r.typed  = 1'b0;
    r.res    = '0;
    return r;
  endfunction

  function automatic step_row_t row_smp(input logic [SAMPLE_W-1:0] s);
    step_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = '0;
    r.data   = '0;
    r.smp    = s;
    r.typed  = 1'b0;
    r.res    = '0;
    return r;
  endfunction

  function automatic step_row_t row_typed(input logic [SAMPLE_W-1:0] s,
                                          input int lvl, input int mean,
                                          input int blend, input bit act,
                                          input bit ld);
    step_row_t r;
    r = row_smp(s);
    r.typed = 1'b1;
    r.res   = {lvl[LEVEL_W-1:0], mean[LEVEL_W-1:0], blend[LEVEL_W-1:0], act, ld};
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input step_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Threshold register data: extremes often, bit 11 is don't-care garbage.
  function automatic logic [CFG_DATA_W-1:0] pick_thr_data();
    logic [LEVEL_W-1:0] thr;
    case ($urandom_range(0, 5))
      0:       thr = '0;
      1:       thr = FULL_SCALE;
      2:       thr = '1;      // above full scale, flag never set
      default: thr = LEVEL_W'($urandom_range(0, 2047));
    endcase
    return {1'($urandom_range(0, 1)), thr};
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one sample item, in bursts with random gaps
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [SAMPLE_W-1:0] s, input bit use_typed,
                           input level_res_t typed_res);
    int         gap;
    level_res_t exp_res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      // with no gap valid stays up, so it is never dropped and raised at once
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    // the predictor runs on every item so its history stays in step
    exp_res = predict_level(s);
    if (use_typed) exp_res = typed_res;
    expected_levels.insert(expected_levels.size(), exp_res);
    samples_sent++;
    burst_left--;
  endtask

  // Register write, only once the block has drained. This pause doubles as
  // the hold-off where the sender waits for every outstanding result.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    in_valid  <= 1'b0;
    burst_left = 0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_GAIN:       gain_r     = d[GAIN_W-1:0];
      REG_WINDOW:     window_r   = d[WINLEN_W-1:0];
      REG_ACTIVE_THR: act_thr_r  = d[LEVEL_W-1:0];
      REG_LOUD_THR:   loud_thr_r = d[LEVEL_W-1:0];
      default: ;  // out of range, dropped
    endcase
    reg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: check accepted results, then pick next cycle's stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    level_res_t got;
    level_res_t want;
    bit         nxt;
    if (!rst && out_valid && !out_stall) begin
      got = {level, mean_level, blended_level, active, loud};
      results_seen++;
      if (expected_levels.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("[%0t] result with nothing expected: level=%0d mean=%0d blend=%0d",
                   $realtime, got.level, got.mean, got.blend);
      end else begin
        want = expected_levels.pop_front();
        if (got.level !== want.level || got.mean !== want.mean ||
            got.blend !== want.blend || got.active !== want.active ||
            got.loud !== want.loud) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: exp lvl=%0d mean=%0d blend=%0d act=%0b loud=%0b",
                     $realtime, want.level, want.mean, want.blend, want.active,
                     want.loud,
                     ", got lvl=%0d mean=%0d blend=%0d act=%0b loud=%0b",
                     got.level, got.mean, got.blend, got.active, got.loud);
        end
      end
    end
    // new stall pattern once the current one has run out
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 400);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:  nxt = 1'b0;
      RX_LIGHT: nxt = ($urandom_range(0, 3) == 0);
      RX_HEAVY: nxt = ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_stall = !run_stall;
          run_left  = $urandom_range(1, MAX_RUN);
        end
        run_left--;
        nxt = run_stall;
      end
    endcase
    out_stall <= nxt;
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no item moving on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int                    thr;
    int                    base;
    logic [SAMPLE_W-1:0]   s;
    logic [CFG_DATA_W-1:0] d;
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample    = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    gain_r     = GAIN_RESET;
    window_r   = WINLEN_RESET;
    act_thr_r  = ACTIVE_RESET;
    loud_thr_r = LOUD_RESET;
    foreach (hist[i]) hist[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Defaults: unity gain, window 50, thresholds 80 / 960.
    add_row(row_typed(8'd0, 0, 0, 0, 0, 0));
    // full input at unity clamps; mean over 50 with one full-scale entry
    add_row(row_typed(8'd255, 2032, 40, 1635, 1, 1));
    add_row(row_smp(8'd5));    // level 80, exactly on active
    add_row(row_smp(8'd6));
    add_row(row_smp(8'd60));   // level 960, exactly on loud
    add_row(row_smp(8'd61));
    // window zero behaves as one: mean follows level
    add_row(row_cfg(REG_WINDOW, 12'd0));
    add_row(row_typed(8'd255, 2032, 2032, 2032, 1, 1));
    add_row(row_typed(8'd0, 0, 0, 0, 0, 0));
    // gain zero gives level zero
    add_row(row_cfg(REG_GAIN, 12'd0));
    add_row(row_typed(8'd255, 0, 0, 0, 0, 0));
    add_row(row_cfg(REG_GAIN, 12'd4095));
    add_row(row_typed(8'd1, 255, 255, 255, 1, 0));
    add_row(row_typed(8'd255, 2032, 2032, 2032, 1, 1));
    // window above depth acts as the depth; changed with history in place
    add_row(row_cfg(REG_WINDOW, 12'd127));
    add_row(row_smp(8'haa));
    add_row(row_smp(8'h55));
    // thresholds above and at full scale: flags stay low
    add_row(row_cfg(REG_ACTIVE_THR, 12'd2047));
    add_row(row_cfg(REG_LOUD_THR, CFG_DATA_W'(FULL_SCALE)));
    add_row(row_smp(8'd255));
    // write past the last register is dropped
    add_row(row_cfg(BAD_IDX_FIRST, 12'hfff));
    add_row(row_cfg(BAD_IDX_LAST, 12'h000));
    add_row(row_smp(8'd255));
    add_row(row_cfg(REG_WINDOW, 12'd64));
    add_row(row_cfg(REG_ACTIVE_THR, 12'd0));
    add_row(row_cfg(REG_LOUD_THR, 12'd0));
    add_row(row_smp(8'd1));
    add_row(row_cfg(REG_GAIN, 12'd16));
    add_row(row_smp(8'd255));
    add_row(row_smp(8'd0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_item(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].res);
    end
    settings++;

    // Random phases: fresh settings, history carried over from phase to phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       d = 12'd0;
        1:       d = 12'd4095;
        2:       d = GAIN_RESET;
        default: d = CFG_DATA_W'($urandom_range(0, 4095));
      endcase
      write_reg(REG_GAIN, d);
      // mostly short windows, extremes now and then; upper data bits garbage
      case ($urandom_range(0, 7))
        0:       d = 12'd0;
        1:       d = 12'd1;
        2:       d = CFG_DATA_W'(DEPTH);
        3:       d = 12'd127;
        4:       d = CFG_DATA_W'($urandom_range(0, 127));
        default: d = CFG_DATA_W'($urandom_range(1, 16));
      endcase
      d[CFG_DATA_W-1:WINLEN_W] = (CFG_DATA_W-WINLEN_W)'($urandom_range(0, 31));
      write_reg(REG_WINDOW, d);
      write_reg(REG_ACTIVE_THR, pick_thr_data());
      write_reg(REG_LOUD_THR, pick_thr_data());
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(BAD_IDX_LAST, BAD_IDX_FIRST)),
                  CFG_DATA_W'($urandom_range(0, 4095)));
      settings++;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0: s = 8'd0;
          1: s = 8'd255;
          2, 3, 4: begin
            // aim the level at one of the thresholds
            thr = ($urandom_range(0, 1) == 0) ? int'(act_thr_r) : int'(loud_thr_r);
            if (gain_r == 0) base = $urandom_range(0, 255);
            else base = (thr * 16) / int'(gain_r) + int'($urandom_range(0, 2)) - 1;
            if (base < 0) base = 0;
            if (base > 255) base = 255;
            s = base[SAMPLE_W-1:0];
          end
          default: s = SAMPLE_W'($urandom_range(0, 255));
        endcase
        send_item(s, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_levels.size() != 0) begin
      $display("%0d expected results never arrived", expected_levels.size());
      fail_count += expected_levels.size();
    end

    $display("Run covered %0d samples and %0d results over %0d register settings",
             samples_sent, results_seen, settings);
    $display("(%0d register writes, gain, window and threshold extremes included)",
             reg_writes);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
